// ===== rtl/color_temperature_to_rgb_defines.svh =====
// Assertion macros used by the checker file
`ifndef COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH
`define COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH

// implication checked every clock outside reset
`define CTR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// implication with the consequent checked in the next cycle
`define CTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== rtl/ctr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctr_pkg
// Constants, table and coefficient types for the color temperature converter.
// ----------------------------------------------------------------------------
package ctr_pkg;

  localparam int KelvinW = 16;
  localparam int ChanW   = 8;
  localparam int OutW    = 3 * ChanW;
  localparam int Latency = 6;

  localparam logic [29:0] Ln2Q30   = 30'd744261118;
  localparam logic [18:0] Ln100Q16 = 19'd301804;
  localparam logic [KelvinW-1:0] KMin   = 16'd1000;
  localparam logic [KelvinW-1:0] KSplit = 16'd6600;
  localparam logic [KelvinW-1:0] KBlue0 = 16'd2000;

  // one fit: Q16 coefficients and offset in kelvin
  typedef struct packed {
    logic signed [25:0] a;
    logic signed [17:0] b;
    logic signed [23:0] c;
    logic [KelvinW-1:0] off;
  } fit_t;

  localparam fit_t FitGreenLo = '{a: -26'sd10174782, b: -18'sd29227,
                                  c: 24'sd6847998, off: 16'd200};
  localparam fit_t FitBlue    = '{a: -26'sd16696564, b: 18'sd54225,
                                  c: 24'sd7581201, off: 16'd1000};
  localparam fit_t FitRed     = '{a: 26'sd23067158, b: 18'sd7485,
                                  c: -24'sd2638064, off: 16'd5500};
  localparam fit_t FitGreenHi = '{a: 26'sd21328653, b: 18'sd5206,
                                  c: -24'sd1840598, off: 16'd5000};

  // log2(1 + i/16) in Q16
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    case (i)
      5'd0:  log2_tab = 17'd0;
      5'd1:  log2_tab = 17'd5732;
      5'd2:  log2_tab = 17'd11136;
      5'd3:  log2_tab = 17'd16248;
      5'd4:  log2_tab = 17'd21098;
      5'd5:  log2_tab = 17'd25711;
      5'd6:  log2_tab = 17'd30109;
      5'd7:  log2_tab = 17'd34312;
      5'd8:  log2_tab = 17'd38336;
      5'd9:  log2_tab = 17'd42196;
      5'd10: log2_tab = 17'd45904;
      5'd11: log2_tab = 17'd49472;
      5'd12: log2_tab = 17'd52911;
      5'd13: log2_tab = 17'd56229;
      5'd14: log2_tab = 17'd59434;
      5'd15: log2_tab = 17'd62534;
      5'd16: log2_tab = 17'd65536;
      default: log2_tab = 17'd0;
    endcase
  endfunction

endpackage

// ===== rtl/ctr_fit.sv =====
// ----------------------------------------------------------------------------
// ctr_fit
// Pipelined a + b*x + c*ln(x) evaluation of one channel, six stages.
// ----------------------------------------------------------------------------
module ctr_fit (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ctr_pkg::KelvinW-1:0]   n,
  input  ctr_pkg::fit_t                 fit,
  output logic [ctr_pkg::ChanW-1:0]     chan
);

  // q = (x * RecipQ) >> 37 equals floor(x/25) for any x < 2^32
  localparam logic [32:0] RecipQ = 33'd5497558139;
  // (r * RecipR) >> 10 equals floor(r * 2^14 / 25) for r < 25
  localparam logic [23:0] RecipR = 24'd671089;

  // stage 1: exponent and table interpolation operands
  logic [3:0]  e1;
  logic [11:0] frac1;
  logic [16:0] lo1, hi1;
  logic [ctr_pkg::KelvinW-1:0] n1;
  ctr_pkg::fit_t fit1;

  logic [3:0]  e_c;
  logic [15:0] m_c;
  logic [31:0] nsh;

  always_comb begin
    e_c = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (n[i]) e_c = 4'(i);
    end
    nsh = {16'd0, n} << (5'd16 - {1'b0, e_c});
    m_c = nsh[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1    <= e_c;
      frac1 <= m_c[11:0];
      lo1   <= ctr_pkg::log2_tab({1'b0, m_c[15:12]});
      hi1   <= ctr_pkg::log2_tab({1'b0, m_c[15:12]} + 5'd1);
      n1    <= n;
      fit1  <= fit;
    end
  end

  // stage 2: log2 in Q16, b*n
  logic [19:0] lg2;
  logic signed [35:0] bn2;
  ctr_pkg::fit_t fit2;
  logic [28:0] prod_c;

  always_comb begin
    prod_c = 29'(hi1 - lo1) * 29'(frac1) + 29'd2048;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg2  <= {e1, 16'd0} + {3'd0, lo1} + 20'(prod_c[28:12]);
      bn2  <= fit1.b * $signed({1'b0, n1});
      fit2 <= fit1;
    end
  end

  // stage 3: ln via ln2 multiply; |b*n| split as 25*q + r
  // b*n*2^16/100 = b*n*2^14/25, truncated toward zero on the magnitude
  logic signed [20:0] ln3;
  logic [31:0] x3;
  logic [27:0] q3;
  logic neg3;
  ctr_pkg::fit_t fit3;
  logic [49:0] p_c;
  logic [31:0] bmag;
  logic [64:0] qprod;

  always_comb begin
    p_c   = 50'(lg2) * 50'(ctr_pkg::Ln2Q30) + (50'd1 << 29);
    bmag  = bn2[35] ? 32'(-bn2) : 32'(bn2);
    qprod = 65'(bmag) * 65'(RecipQ);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln3  <= $signed({1'b0, p_c[49:30]}) - $signed({2'b0, ctr_pkg::Ln100Q16});
      x3   <= bmag;
      q3   <= qprod[64:37];
      neg3 <= bn2[35];
      fit3 <= fit2;
    end
  end

  // stage 4: c*ln; remainder term floor(r*2^14/25)
  logic signed [45:0] cl4;
  logic [27:0] q4;
  logic [13:0] rem4;
  logic neg4;
  ctr_pkg::fit_t fit4;
  logic [4:0]  r_c;
  logic [23:0] rprod;

  always_comb begin
    r_c   = 5'(x3 - (32'(q3) * 32'd25));
    rprod = 24'(r_c) * RecipR;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl4  <= fit3.c * ln3;
      q4   <= q3;
      rem4 <= rprod[23:10];
      neg4 <= neg3;
      fit4 <= fit3;
    end
  end

  // stage 5: a plus signed b term
  logic signed [45:0] cl5;
  logic signed [52:0] ab5;
  logic [41:0] btmag_c;
  logic signed [52:0] bt_c;

  always_comb begin
    btmag_c = {q4, 14'd0} + 42'(rem4);
    bt_c    = neg4 ? -$signed({11'd0, btmag_c}) : $signed({11'd0, btmag_c});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cl5 <= cl4;
      ab5 <= $signed({fit4.a, 16'd0}) + bt_c;
    end
  end

  // stage 6: final sum, round, clamp
  logic signed [53:0] s_c;
  logic [53:0] r6_c;
  always_comb begin
    s_c  = 54'(ab5) + 54'(cl5);
    r6_c = 54'(s_c) + (54'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_c < 0) chan <= '0;
      else if (r6_c[53:32] > 22'd255) chan <= 8'hff;
      else chan <= r6_c[39:32];
    end
  end

endmodule

// ===== rtl/color_temperature_to_rgb.sv =====
// ----------------------------------------------------------------------------
// color_temperature_to_rgb
// Kelvin to 8-bit RGB using piecewise log fits, fully pipelined.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)
// s_axis   in   kelvin[15:0]
// m_axis   out  red[7:0] green[15:8] blue[23:16]
// One word per cycle while the output is not stalled; results come out of the fit pipeline.
// The whole pipe advances when the output register is empty or taken.
// A stall freezes every stage; nothing is dropped or repeated.
// rst clears the valid bits only.
module color_temperature_to_rgb (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // kelvin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // red, green, blue
);

  localparam int L = ctr_pkg::Latency;

  logic en;
  logic [L-1:0] vld;
  logic [L-1:0] lo_flag, b0_flag;
  logic [15:0] k;
  logic lo_c;
  logic [15:0] n1, n2;
  ctr_pkg::fit_t f1, f2;
  logic [7:0] c1, c2;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[L-1];

  always_comb begin
    k = (s_axis_tdata < ctr_pkg::KMin) ? ctr_pkg::KMin : s_axis_tdata;
    lo_c = k < ctr_pkg::KSplit;
    f1 = lo_c ? ctr_pkg::FitGreenLo : ctr_pkg::FitGreenHi;
    f2 = lo_c ? ctr_pkg::FitBlue : ctr_pkg::FitRed;
    n1 = k - f1.off;
    n2 = k - f2.off;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[L-2:0], s_axis_tvalid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_flag <= {lo_flag[L-2:0], lo_c};
      b0_flag <= {b0_flag[L-2:0], k <= ctr_pkg::KBlue0};
    end
  end

  ctr_fit u_fit_g (.clk(clk), .en(en), .n(n1), .fit(f1), .chan(c1));
  ctr_fit u_fit_x (.clk(clk), .en(en), .n(n2), .fit(f2), .chan(c2));

  always_comb begin
    if (lo_flag[L-1]) begin
      m_axis_tdata = {(b0_flag[L-1] ? 8'd0 : c2), c1, 8'hff};
    end else begin
      m_axis_tdata = {8'hff, c1, c2};
    end
  end

endmodule

// ===== rtl/ctr_checker.sv =====
// ----------------------------------------------------------------------------
// ctr_checker
// Port-level checks for the color temperature converter.
// ----------------------------------------------------------------------------
`include "color_temperature_to_rgb_defines.svh"
module ctr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  logic red_ff, blue_ff;

  // one of red or blue is always pinned at full scale
  assign red_ff  = m_axis_tdata[7:0] == 8'hff;
  assign blue_ff = m_axis_tdata[23:16] == 8'hff;

  `CTR_ASSERT_IMPL(a_ready, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `CTR_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `CTR_ASSERT_IMPL(a_sat, clk, rst, m_axis_tvalid, red_ff || blue_ff)
endmodule

bind color_temperature_to_rgb ctr_checker u_chk (.*);

// ===== bench/color_temperature_to_rgb_test.sv =====
// ----------------------------------------------------------------------------
// color_temperature_to_rgb_test
// Stream bench for the kelvin to RGB converter: a fixed-point predictor of the
// piecewise log fits is checked word by word against the block output.
// ----------------------------------------------------------------------------
module color_temperature_to_rgb_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  localparam int StallLimit = 2000;
  localparam logic [15:0] Corner [18] = '{16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001,
                                          16'd1999, 16'd2000, 16'd2001, 16'd5500,
                                          16'd6599, 16'd6600, 16'd6601, 16'd10000,
                                          16'd40000, 16'hfffe, 16'hffff, 16'h5555,
                                          16'haaaa};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // kelvin
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // red, green, blue

  logic [15:0] kelvin_q[$];
  rgb_t        rgb_q[$];
  int          src_idle = 36;
  int          snk_idle = 87;
  bit          hold_src = 1'b0;
  int          n_err = 0;
  int          n_words = 0;
  int          quiet = 0;

  color_temperature_to_rgb DUT (.*);

  always #1 clk = ~clk;

  function automatic logic [31:0] log2_fix(input logic [31:0] n);
    int unsigned e, m, idx, frac, lo, hi;
    e = 0;
    while (e < 15 && (n >> (e + 1)) != 0) e++;
    m = (n << (16 - e)) - 65536;
    idx = (m >> 12) & 15;
    frac = m & 32'hfff;
    lo = ctr_pkg::log2_tab(5'(idx));
    hi = ctr_pkg::log2_tab(5'(idx + 1));
    return (e << 16) + lo + (((hi - lo) * frac + 2048) >> 12);
  endfunction

  function automatic logic [7:0] eval_fit(input ctr_pkg::fit_t f, input logic [15:0] k);
    longint sum, lnx, n;
    longint unsigned p, r;
    n = longint'(k) - longint'(f.off);
    p = longint'(log2_fix(32'(n))) * longint'(ctr_pkg::Ln2Q30);
    lnx = longint'((p + (64'd1 << 29)) >> 30) - longint'(ctr_pkg::Ln100Q16);
    sum = longint'(f.a) * 65536;
    sum += (longint'(f.b) * n * 65536) / 100;
    sum += longint'(f.c) * lnx;
    if (sum < 0) return 8'd0;
    r = (longint'(sum) + (64'd1 << 31)) >> 32;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic rgb_t kelvin_to_rgb(input logic [15:0] kin);
    rgb_t o;
    logic [15:0] k;
    k = (kin < ctr_pkg::KMin) ? ctr_pkg::KMin : kin;
    if (k < ctr_pkg::KSplit) begin
      o.red = 8'd255;
      o.green = eval_fit(ctr_pkg::FitGreenLo, k);
      o.blue = (k <= ctr_pkg::KBlue0) ? 8'd0 : eval_fit(ctr_pkg::FitBlue, k);
    end else begin
      o.red = eval_fit(ctr_pkg::FitRed, k);
      o.green = eval_fit(ctr_pkg::FitGreenHi, k);
      o.blue = 8'd255;
    end
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        rgb_q.push_back(kelvin_to_rgb(s_axis_tdata));
        void'(kelvin_q.pop_front());
      end
      if (kelvin_q.size() != 0 && !hold_src && $urandom_range(99) >= src_idle) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= kelvin_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        rgb_t got, want;
        got = m_axis_tdata;
        n_words <= n_words + 1;
        if (rgb_q.size() == 0) begin
          $error("unexpected word %h", got);
          n_err++;
        end else begin
          want = rgb_q.pop_front();
          if (got.red !== want.red) begin
            $error("red expected %0d actual %0d", want.red, got.red);
            n_err++;
          end
          if (got.green !== want.green) begin
            $error("green expected %0d actual %0d", want.green, got.green);
            n_err++;
          end
          if (got.blue !== want.blue) begin
            $error("blue expected %0d actual %0d", want.blue, got.blue);
            n_err++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic load_random(input int cnt);
    repeat (cnt) begin
      case ($urandom_range(5))
        0: kelvin_q.push_back(16'($urandom_range(1100)));
        1: kelvin_q.push_back(16'($urandom_range(2100, 1900)));
        2: kelvin_q.push_back(16'($urandom_range(6700, 6500)));
        3: kelvin_q.push_back(16'($urandom_range(40000, 1000)));
        default: kelvin_q.push_back(16'($urandom));
      endcase
    end
  endtask

  task automatic drain();
    while (kelvin_q.size() != 0 || s_axis_tvalid || rgb_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (Corner[i]) kelvin_q.push_back(Corner[i]);
    load_random(520);
    drain();
    // sender held off with words queued, after the pipe has drained
    hold_src = 1'b1;
    load_random(20);
    repeat (20) @(posedge clk);
    hold_src = 1'b0;
    drain();
    src_idle = 87;
    snk_idle = 36;
    load_random(530);
    drain();
    src_idle = 0;
    snk_idle = 0;
    load_random(530);
    drain();
    repeat (4 * ctr_pkg::Latency) @(posedge clk);
    $display("Checked %0d RGB words over corner, band-edge and random kelvin values",
             n_words);
    $display("with three idle/stall mixes and one full drain hold-off.");
    if (n_err == 0 && rgb_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ctr_pkg.sv
rtl/ctr_fit.sv
rtl/color_temperature_to_rgb.sv
rtl/ctr_checker.sv
bench/color_temperature_to_rgb_test.sv
